[design/sscc_pkg.sv]
// ----------------------------------------------------------------------------
// sscc_pkg
// Shared constants, register indexes and controller/datapath structs for the
// Sassenfeld criterion checker.
// ----------------------------------------------------------------------------
package sscc_pkg;

  // fixed field and register widths
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned ROW_OUT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CRITERION_MODE = CFG_IDX_W'(1);

  // criterion modes
  localparam logic MODE_ROW        = 1'b0;
  localparam logic MODE_SASSENFELD = 1'b1;

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic              MODE_RESET = MODE_SASSENFELD;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;       // element beat accepted, latch magnitude and read beta
    logic mul;        // form the weighted term
    logic acc;        // add term to row sum, advance column
    logic check;      // compare row sum against diagonal, track first fail
    logic div_start;  // start beta division
    logic row_done;   // store beta, clear row state, advance row
    logic emit;       // load the result register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic row_end;     // current element is the last of its row
    logic last_row;    // current row is the last of the matrix
    logic sassenfeld;  // Sassenfeld mode selected
    logic pass;        // row sum below diagonal magnitude
    logic div_done;    // beta quotient ready
    logic out_free;    // result register can take a new beat
  } ctrl_status_t;

endpackage

[design/sscc_if.sv]
// ----------------------------------------------------------------------------
// sscc_if
// Valid/ready stream interfaces for matrix elements and check results.
// ----------------------------------------------------------------------------
interface sscc_elem_if;
  logic                                valid;
  logic                                ready;
  logic signed [sscc_pkg::ELEM_W-1:0]  element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface sscc_res_if;
  logic                              valid;
  logic                              ready;
  logic                              criterion_met;
  logic [sscc_pkg::ROW_OUT_W-1:0]    failing_row;

  modport source (output valid, output criterion_met, output failing_row, input ready);
  modport sink   (input valid, input criterion_met, input failing_row, output ready);
endinterface

[design/sscc_divider.sv]
// ----------------------------------------------------------------------------
// sscc_divider
// Restoring divider, one quotient bit per cycle: floor(a * 2^FRAC_BITS / b)
// for a < b, used for the beta of a passing row.
// ----------------------------------------------------------------------------
module sscc_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sscc_pkg::ELEM_W-1:0]   dividend_i,
  input  logic [sscc_pkg::ELEM_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [FRAC_BITS-1:0]          quotient_o
);
  import sscc_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned REM_W = ELEM_W + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;

  logic [REM_W-1:0] rem_shift;
  logic             fits;

  // one restoring step
  assign rem_shift = {rem_q[ELEM_W-1:0], 1'b0};
  assign fits      = rem_shift >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(FRAC_BITS);
      rem_d  = {1'b0, dividend_i};
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? (rem_shift - {1'b0, divisor_i}) : rem_shift;
      quo_d = {quo_q[FRAC_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/sscc_datapath.sv]
// ----------------------------------------------------------------------------
// sscc_datapath
// Configuration registers, row/column counters, beta store, weighting
// multiplier, saturating row accumulator, row check and result register.
// ----------------------------------------------------------------------------
module sscc_datapath #(
  parameter int unsigned MAX_SIZE  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sscc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sscc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [sscc_pkg::ELEM_W-1:0]       element_value_i,
  input  logic                              res_ready_i,
  input  sscc_pkg::ctrl_cmd_t               cmd_i,
  output sscc_pkg::ctrl_status_t            status_o,
  output logic                              res_valid_o,
  output logic                              criterion_met_o,
  output logic [sscc_pkg::ROW_OUT_W-1:0]    failing_row_o
);
  import sscc_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_SIZE);
  localparam int unsigned CW    = (IW > SIZE_W) ? IW : SIZE_W;
  localparam int unsigned BW    = FRAC_BITS + 1;
  localparam int unsigned PW    = ELEM_W + BW;
  localparam int unsigned TW    = PW - FRAC_BITS;
  localparam logic [BW-1:0] ONE_BETA = BW'(1) << FRAC_BITS;

  // configuration
  logic [SIZE_W-1:0] size_q;
  logic              mode_q;
  logic              restart;

  // counters and row state
  logic [IW-1:0]     row_q, col_q;
  logic [SUM_W-1:0]  sum_q;
  logic [ELEM_W-1:0] diag_q;
  logic              fail_q;
  logic [IW-1:0]     first_fail_q;
  logic              pass_q;

  // element pipeline
  logic [ELEM_W-1:0] mag_q;
  logic [BW-1:0]     beta_rd_q;
  logic              is_diag_q, weighted_q;
  logic [PW-1:0]     prod_q;

  // beta store
  logic [BW-1:0]     beta_mem [MAX_SIZE];

  // result register
  logic                 res_valid_q;
  logic                 res_met_q;
  logic [ROW_OUT_W-1:0] res_row_q;

  logic [CW-1:0]     size_ext, n_eff, last_idx;
  logic [ELEM_W-1:0] mag;
  logic [TW-1:0]     term;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic              pass;
  logic              row_end, last_row;
  logic              div_done;
  logic [FRAC_BITS-1:0] quotient;

  // size in use, clamped to 1..MAX_SIZE
  assign size_ext = CW'(size_q);
  always_comb begin
    n_eff = size_ext;
    if (size_q == '0) begin
      n_eff = CW'(1);
    end else if (size_ext > CW'(MAX_SIZE)) begin
      n_eff = CW'(MAX_SIZE);
    end
  end
  assign last_idx = n_eff - CW'(1);
  assign row_end  = CW'(col_q) == last_idx;
  assign last_row = CW'(row_q) == last_idx;

  // element magnitude, exact for the most negative value
  assign mag = element_value_i[ELEM_W-1] ? (~element_value_i + ELEM_W'(1)) : element_value_i;

  // saturating accumulate
  assign term     = prod_q[PW-1:FRAC_BITS];
  assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(term);
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // row criterion
  assign pass = sum_q < SUM_W'(diag_q);

  assign restart = cfg_we_i &&
                   (cfg_index_i == REG_MATRIX_SIZE || cfg_index_i == REG_CRITERION_MODE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MATRIX_SIZE:    size_q <= cfg_data_i[SIZE_W-1:0];
        REG_CRITERION_MODE: mode_q <= cfg_data_i[0];
        default:            ;
      endcase
    end
  end

  // counters, row sum, diagonal and failure tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      col_q        <= '0;
      sum_q        <= '0;
      diag_q       <= '0;
      fail_q       <= 1'b0;
      first_fail_q <= '0;
      pass_q       <= 1'b0;
    end else if (restart) begin
      row_q        <= '0;
      col_q        <= '0;
      sum_q        <= '0;
      diag_q       <= '0;
      fail_q       <= 1'b0;
      first_fail_q <= '0;
    end else begin
      if (cmd_i.take && col_q == row_q) begin
        diag_q <= mag;
      end
      if (cmd_i.acc) begin
        if (!is_diag_q) begin
          sum_q <= sum_sat;
        end
        if (!row_end) begin
          col_q <= col_q + IW'(1);
        end
      end
      if (cmd_i.check) begin
        pass_q <= pass;
        if (!pass && !fail_q) begin
          fail_q       <= 1'b1;
          first_fail_q <= row_q;
        end
      end
      if (cmd_i.row_done) begin
        sum_q  <= '0;
        diag_q <= '0;
        col_q  <= '0;
        if (last_row) begin
          row_q        <= '0;
          fail_q       <= 1'b0;
          first_fail_q <= '0;
        end else begin
          row_q <= row_q + IW'(1);
        end
      end
    end
  end

  // element capture and weighting multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mag_q      <= mag;
      is_diag_q  <= col_q == row_q;
      weighted_q <= (col_q < row_q) && (mode_q == MODE_SASSENFELD);
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(mag_q) * PW'(weighted_q ? beta_rd_q : ONE_BETA);
    end
  end

  // beta store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_done && mode_q == MODE_SASSENFELD) begin
      beta_mem[row_q] <= pass_q ? BW'(quotient) : ONE_BETA;
    end
    if (cmd_i.take) begin
      beta_rd_q <= beta_mem[col_q];
    end
  end

  sscc_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q[ELEM_W-1:0]),
    .divisor_i  (diag_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_met_q <= !fail_q;
      res_row_q <= fail_q ? ROW_OUT_W'(first_fail_q) : '0;
    end
  end

  assign status_o.row_end    = row_end;
  assign status_o.last_row   = last_row;
  assign status_o.sassenfeld = mode_q == MODE_SASSENFELD;
  assign status_o.pass       = pass;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !res_valid_q || res_ready_i;

  assign res_valid_o     = res_valid_q;
  assign criterion_met_o = res_met_q;
  assign failing_row_o   = res_row_q;

endmodule

[design/sscc_ctrl.sv]
// ----------------------------------------------------------------------------
// sscc_ctrl
// Sequencer for one element at a time: capture, multiply, accumulate, and at
// a row end the check, beta division for a passing Sassenfeld row and wrap-up.
// ----------------------------------------------------------------------------
module sscc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    elem_valid_i,
  output logic                    elem_ready_o,
  input  sscc_pkg::ctrl_status_t  status_i,
  output sscc_pkg::ctrl_cmd_t     cmd_o
);
  import sscc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (elem_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.row_end ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.sassenfeld && status_i.pass) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_ROW;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        // last row waits for room in the result register
        if (!status_i.last_row || status_i.out_free) begin
          cmd_o.row_done = 1'b1;
          cmd_o.emit     = status_i.last_row;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign elem_ready_o = state_q == S_IDLE;

endmodule

[design/sassenfeld_criterion_checker_top.sv]
// ----------------------------------------------------------------------------
// sassenfeld_criterion_checker_top
// Convergence check (row criterion or Sassenfeld) on a streamed square matrix.
// ----------------------------------------------------------------------------
// Elements arrive in row-major order, one signed Q15.16 value per beat. Each
// element passes capture with beta read, multiply on the single shared
// weighting multiplier and accumulate before the next one is taken. The
// last element of a row adds the check and row wrap-up, plus the bit-serial
// beta division in Sassenfeld mode when the row passes. One result beat
// follows the last element of the matrix; the block keeps taking elements
// of the next matrix while that beat waits, and only the next matrix end
// stalls on it. A write to the size or mode register restarts the matrix.
// The beta store has no reset: betas are only read for rows already ended
// in the current matrix.
module sassenfeld_criterion_checker_top #(
  parameter int unsigned MAX_SIZE  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sscc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sscc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sscc_elem_if.sink                         elem_i,
  sscc_res_if.source                        res_o
);
  import sscc_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer
  sscc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_valid_i (elem_i.valid),
    .elem_ready_o (elem_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // arithmetic and storage
  sscc_datapath #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .element_value_i (elem_i.element_value),
    .res_ready_i     (res_o.ready),
    .cmd_i           (cmd),
    .status_o        (status),
    .res_valid_o     (res_o.valid),
    .criterion_met_o (res_o.criterion_met),
    .failing_row_o   (res_o.failing_row)
  );

  // a result beat is only produced at the end of the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (status.last_row && cmd.row_done))
    else $error("result emitted before the last row ended");

  // an accepted element keeps the input closed for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elem_i.valid && elem_i.ready) |=> !elem_i.ready)
    else $error("element accepted while previous one still in work");

  // the beta division keeps the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> (!elem_i.ready && !cmd.row_done))
    else $error("row wrapped up before the divider finished");

  // an emitted result is presented in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> res_o.valid)
    else $error("emitted result not presented");

endmodule

[verif/sassenfeld_criterion_checker_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sassenfeld_criterion_checker_top_test
// Streams square matrices into the convergence checker and compares every
// verdict beat with an in-bench model of the row and Sassenfeld criteria.
// A short table covers extremes, zero diagonals, both modes and register
// side effects; random matrices of mostly small sizes follow, with bursty
// element traffic, receiver back-pressure and one long result hold-off.
// ----------------------------------------------------------------------------
module sassenfeld_criterion_checker_top_test;
  import sscc_pkg::*;

  localparam int unsigned MAX_SIZE      = 16;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned DIRECTED_ROWS = 31;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic                 met;
    logic [ROW_OUT_W-1:0] fail_row;
  } verdict_t;

  typedef enum logic {ROW_ELEMENT, ROW_WRITE} stim_kind_e;

  typedef struct {
    stim_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_idx;   // unused on element rows
    logic [ELEM_W-1:0]    value;
    bit                   typed;
    logic                 met;
    logic [ROW_OUT_W-1:0] fail_row;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sscc_elem_if elem_bus ();
  sscc_res_if  res_bus ();

  sassenfeld_criterion_checker_top #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .elem_i      (elem_bus),
    .res_o       (res_bus)
  );

  // model state
  logic [SIZE_W-1:0]    size_reg;
  logic                 mode_reg;
  logic [FRAC_BITS:0]   beta_mem [MAX_SIZE];
  logic [SUM_W-1:0]     acc_sum;
  logic [ELEM_W-1:0]    diag_mag;
  int unsigned          row_idx;
  int unsigned          col_idx;
  bit                   fail_flag;
  logic [ROW_OUT_W-1:0] fail_at;

  verdict_t    pending_verdicts [$];
  int unsigned mismatch_count;
  int unsigned elements_sent;
  int unsigned met_count;
  int unsigned unmet_count;
  int unsigned row_mode_mats;
  int unsigned sass_mode_mats;
  int unsigned cycle_count;
  int unsigned hold_token;
  int unsigned burst_left;
  bit          gapless;

  // extremes, zero diagonals, both modes, size clamp and ignored indexes
  stim_row_t directed_tbl [DIRECTED_ROWS] = '{
    '{ROW_ELEMENT, '0, 32'h7FFF_FFFF, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h8000_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_WRITE, REG_MATRIX_SIZE, 32'd1, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h8000_0000, 1'b1, 1'b1, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b1, 1'b0, 4'd0},
    '{ROW_WRITE, REG_CRITERION_MODE, 32'(MODE_ROW), 1'b0, 1'b0, 4'd0},
    '{ROW_WRITE, REG_MATRIX_SIZE, 32'd2, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0004_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'hFFFF_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0001_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'hFFFC_0000, 1'b1, 1'b1, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0004_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0001_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0005_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0004_0000, 1'b1, 1'b0, 4'd1},
    '{ROW_WRITE, REG_CRITERION_MODE, 32'(MODE_SASSENFELD), 1'b0, 1'b0, 4'd0},
    '{ROW_WRITE, REG_MATRIX_SIZE, 32'd3, 1'b0, 1'b0, 4'd0},
    // row criterion fails on row 1, the beta weighting lets it pass
    '{ROW_ELEMENT, '0, 32'h0002_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0001_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'hFFFD_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0002_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0000_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0001_0000, 1'b0, 1'b0, 4'd0},
    '{ROW_WRITE, REG_MATRIX_SIZE, 32'd0, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'h0005_0000, 1'b1, 1'b1, 4'd0},
    '{ROW_WRITE, REG_UNUSED_3, 32'h1F, 1'b0, 1'b0, 4'd0},
    '{ROW_ELEMENT, '0, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd0}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_size();
    if (size_reg == '0) return 1;
    if (size_reg > MAX_SIZE) return MAX_SIZE;
    return size_reg;
  endfunction

  function automatic void restart_matrix_model();
    acc_sum   = '0;
    diag_mag  = '0;
    row_idx   = 0;
    col_idx   = 0;
    fail_flag = 1'b0;
    fail_at   = '0;
  endfunction

  // fold one element into the model, returns 1 when the matrix verdict is due
  function automatic bit fold_element(input logic [ELEM_W-1:0] raw, output verdict_t v);
    int unsigned    n;
    logic [31:0]    mag;
    logic [63:0]    term;
    logic [63:0]    quotient;
    logic [SUM_W:0] total;
    bit             row_ok;
    n    = effective_size();
    mag  = raw[31] ? (~raw + 32'd1) : raw;
    v    = '{met: 1'b0, fail_row: '0};
    term = {32'd0, mag};
    if (col_idx == row_idx) begin
      diag_mag = mag;
    end else begin
      if (col_idx < row_idx && mode_reg == MODE_SASSENFELD)
        term = ({32'd0, mag} * {47'd0, beta_mem[col_idx]}) >> FRAC_BITS;
      total   = {1'b0, acc_sum} + term[SUM_W:0];
      acc_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
    end
    if (col_idx + 1 < n) begin
      col_idx++;
      return 1'b0;
    end
    // row end: dominance check and beta for later rows
    row_ok = acc_sum < {16'd0, diag_mag};
    if (!row_ok && !fail_flag) begin
      fail_flag = 1'b1;
      fail_at   = row_idx[ROW_OUT_W-1:0];
    end
    if (mode_reg == MODE_SASSENFELD) begin
      if (row_ok) quotient = ({16'd0, acc_sum} << FRAC_BITS) / {32'd0, diag_mag};
      else quotient = 64'd1 << FRAC_BITS;
      beta_mem[row_idx] = quotient[FRAC_BITS:0];
    end
    acc_sum  = '0;
    diag_mag = '0;
    col_idx  = 0;
    if (row_idx + 1 < n) begin
      row_idx++;
      return 1'b0;
    end
    v.met      = !fail_flag;
    v.fail_row = fail_flag ? fail_at : '0;
    restart_matrix_model();
    return 1'b1;
  endfunction

  // register write once every verdict is in and the block has settled
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    elem_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MATRIX_SIZE: begin
        size_reg = data;
        restart_matrix_model();
      end
      REG_CRITERION_MODE: begin
        mode_reg = data[0];
        restart_matrix_model();
      end
      default: ;
    endcase
  endtask

  // offer one element beat, predict on acceptance, then maybe leave a gap
  task automatic send_element(input logic [ELEM_W-1:0] value, input bit typed,
                              input logic t_met, input logic [ROW_OUT_W-1:0] t_row);
    verdict_t v;
    logic     mode_then;
    elem_bus.valid         <= 1'b1;
    elem_bus.element_value <= value;
    @(posedge clk_i);
    while (elem_bus.ready !== 1'b1) @(posedge clk_i);
    mode_then = mode_reg;
    elements_sent++;
    if (fold_element(value, v)) begin
      if (typed) begin
        v.met      = t_met;
        v.fail_row = t_row;
      end
      pending_verdicts.push_back(v);
      if (v.met) met_count++;
      else unmet_count++;
      if (mode_then == MODE_SASSENFELD) sass_mode_mats++;
      else row_mode_mats++;
    end
    @(negedge clk_i);
    if (!gapless) begin
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        elem_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(0, 15);
      end
    end
  endtask

  // random matrix: dominant diagonals mostly, some noise and zero diagonals
  task automatic send_random_matrix(input int unsigned n, input int unsigned count,
                                    input int unsigned split);
    int unsigned dmag;
    int unsigned lim;
    int unsigned mag;
    logic [31:0] val;
    bit          noisy;
    noisy = ($urandom_range(0, 7) == 0);
    dmag  = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == split)
        write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                       CFG_DATA_W'($urandom));
      if (k % n == 0) begin
        case ($urandom_range(0, 19))
          0:       dmag = 0;
          1:       dmag = 32'h8000_0000;
          2:       dmag = 32'h7FFF_FFFF;
          3:       dmag = $urandom_range(0, 32'h8000_0000);
          default: dmag = $urandom_range(32'h100, 32'h4000_0000);
        endcase
      end
      lim = dmag / n;
      if (k % n == k / n) begin
        mag = dmag;
      end else begin
        case ($urandom_range(0, 7))
          0:       mag = $urandom_range(0, 32'h8000_0000);
          1:       mag = 0;
          2:       mag = $urandom_range(0, lim * 3);
          default: mag = $urandom_range(0, lim);
        endcase
      end
      val = $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
      if (noisy) val = $urandom;
      send_element(val, 1'b0, 1'b0, '0);
    end
  endtask

  // receiver ready pattern, plus a long hold-off on request
  initial begin : verdict_sink
    int unsigned rx_cycle;
    int unsigned hold_seen;
    int unsigned hold_left;
    rx_cycle      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 256) % 4)
          0:       res_bus.ready <= 1'b1;
          1:       res_bus.ready <= 1'($urandom_range(0, 1));
          2:       res_bus.ready <= (rx_cycle % 9) < 2;
          default: res_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // compare each verdict beat with the oldest prediction
  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat with no prediction pending");
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (res_bus.criterion_met !== want.met) begin
          $error("criterion_met: expected %0d, got %0d", want.met, res_bus.criterion_met);
          mismatch_count++;
        end
        if (res_bus.failing_row !== want.fail_row) begin
          $error("failing_row: expected %0d, got %0d", want.fail_row, res_bus.failing_row);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned      random_goal;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      mats;
    int unsigned      split;
    int unsigned      pick;
    logic [SIZE_W-1:0] size_data;
    elem_bus.valid         = 1'b0;
    elem_bus.element_value = '0;
    cfg_we_i               = 1'b0;
    cfg_index_i            = REG_MATRIX_SIZE;
    cfg_data_i             = '0;
    rst_ni                 = 1'b0;
    mismatch_count         = 0;
    elements_sent          = 0;
    met_count              = 0;
    unmet_count            = 0;
    row_mode_mats          = 0;
    sass_mode_mats         = 0;
    hold_token             = 0;
    burst_left             = 0;
    gapless                = 1'b0;
    size_reg               = SIZE_RESET;
    mode_reg               = MODE_RESET;
    restart_matrix_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ROW_WRITE)
        write_register(directed_tbl[i].reg_idx, directed_tbl[i].value[CFG_DATA_W-1:0]);
      else
        send_element(directed_tbl[i].value, directed_tbl[i].typed,
                     directed_tbl[i].met, directed_tbl[i].fail_row);
    end

    // random phases, each with its own mode and size
    random_goal = elements_sent + RANDOM_ITEMS;
    phase       = 0;
    while (elements_sent < random_goal) begin
      phase++;
      write_register(REG_CRITERION_MODE,
                     CFG_DATA_W'($urandom_range(0, 1) ? MODE_SASSENFELD : MODE_ROW));
      case (phase)
        1:       size_data = 5'd31;
        2:       size_data = 5'd0;
        3:       size_data = 5'd2;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick == 0) size_data = 5'd0;
          else if (pick == 1) size_data = SIZE_W'($urandom_range(9, 15));
          else size_data = SIZE_W'($urandom_range(1, 6));
        end
      endcase
      write_register(REG_MATRIX_SIZE, size_data);
      n    = effective_size();
      mats = 1 + $urandom_range(0, 48 / (n * n));
      // back-pressure phase: receiver holds off while matrices keep coming
      if (phase == 3) begin
        gapless = 1'b1;
        hold_token++;
        mats = 16;
      end
      for (int unsigned m = 0; m < mats; m++) begin
        split = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n * n - 1) : n * n;
        send_random_matrix(n, n * n, split);
      end
      gapless = 1'b0;
      // abandoned matrix, the next register write restarts it
      if (n > 1 && $urandom_range(0, 3) == 0)
        send_random_matrix(n, $urandom_range(1, n * n - 1), n * n);
    end

    // drain
    elem_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d elements in %0d matrices (%0d row criterion, %0d Sassenfeld)",
             elements_sent, row_mode_mats + sass_mode_mats, row_mode_mats, sass_mode_mats);
    $display("verdicts: %0d met, %0d failed; %0d mismatches",
             met_count, unmet_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/sscc_pkg.sv
design/sscc_if.sv
design/sscc_divider.sv
design/sscc_datapath.sv
design/sscc_ctrl.sv
design/sassenfeld_criterion_checker_top.sv
verif/sassenfeld_criterion_checker_top_test.sv
